// ----- design/lisp_token_splitter_unit_macros.svh -----
// assertion macros for the lisp token splitter
// used by lisp_token_splitter_unit, no other dependencies
`ifndef LISP_TOKEN_SPLITTER_UNIT_MACROS_SVH
`define LISP_TOKEN_SPLITTER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define LTS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lts check failed");
`define LTS_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lts check failed");
`else
`define LTS_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define LTS_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/lts_pkg.sv -----
// types and constants for the lisp token splitter
// no dependencies
package lts_pkg;

    localparam int OUT_BITS    = 16;
    localparam int MAX_RESULTS = 4;
    localparam int CNT_BITS    = 3;
    localparam int IDX_BITS    = 2;

    typedef enum logic [1:0] {
        MODE_WORD   = 2'd0,
        MODE_STRING = 2'd1,
        MODE_SPACE  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        KIND_WORD   = 2'd0,
        KIND_STRING = 2'd1,
        KIND_PUNCT  = 2'd2,
        KIND_SPLICE = 2'd3
    } kind_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] start;
        logic [OUT_BITS-1:0] length;
        kind_t               kind;
        logic                unterm;
    } res_t;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_BTICK  = 8'h60;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;

    function automatic logic is_punct(input logic [7:0] ch);
        return (ch == CH_LPAREN) || (ch == CH_RPAREN) || (ch == CH_LBRACK) ||
               (ch == CH_RBRACK) || (ch == CH_LBRACE) || (ch == CH_RBRACE) ||
               (ch == CH_AT) || (ch == CH_AMP) || (ch == CH_APOS) ||
               (ch == CH_BTICK) || (ch == CH_SEMI);
    endfunction

    function automatic logic is_blank(input logic [7:0] ch);
        return (ch == CH_SPACE) || (ch == CH_NL) || (ch == CH_TAB);
    endfunction

endpackage

// ----- design/lisp_token_splitter_unit.sv -----
// a request is held in the input register, then its tokens are written into the result buffer
// that drives the output; the byte waits there while the buffer still holds undrained tokens
// throughput: one byte per cycle while each byte yields at most one token and tok_stall
// is low; a byte yielding more than one token keeps the next byte in the input register until
// the result buffer drains, one token per cycle while tok_stall is low
// reset clears mode, positions, flags and both valid stages at once
`include "lisp_token_splitter_unit_macros.svh"

module lisp_token_splitter_unit #(
    parameter int POSITION_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          src_valid,
    output logic                          src_stall,
    input  logic [7:0]                    char_code,
    input  logic                          end_of_text,
    output logic                          tok_valid,
    input  logic                          tok_stall,
    output logic [lts_pkg::OUT_BITS-1:0]  token_start,
    output logic [lts_pkg::OUT_BITS-1:0]  token_length,
    output logic [1:0]                    token_kind,
    output logic                          unterminated,
    output logic                          run_last
);
    import lts_pkg::*;

    localparam int P  = POSITION_BITS;
    localparam int LW = P + 1;
    localparam int CW = (LW > OUT_BITS + 1) ? LW : OUT_BITS + 1;
    localparam logic [P-1:0] POS_MAX = {P{1'b1}};

    function automatic logic [OUT_BITS-1:0] clamp_out(input logic [CW-1:0] v);
        if (|v[CW-1:OUT_BITS])
            return {OUT_BITS{1'b1}};
        return v[OUT_BITS-1:0];
    endfunction

    // input register
    logic       src_vld_reg, src_vld_next;
    logic [7:0] ch_reg;
    logic       eot_reg;

    // lexer state
    mode_t         mode_reg, mode_next;
    logic [P-1:0]  pos_reg, pos_next;
    logic [P-1:0]  os_reg, os_next;
    logic          pb_reg, pb_next;
    logic          tp_reg, tp_next;

    // result buffer
    res_t                buf_reg [MAX_RESULTS];
    res_t                buf_next [MAX_RESULTS];
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [IDX_BITS-1:0] idx_reg, idx_next;

    logic src_take, out_take, last_take, buf_free, advance;
    logic [CNT_BITS-1:0] idx_ext;
    logic [CNT_BITS-1:0] new_cnt;

    assign idx_ext      = CNT_BITS'(idx_reg);
    assign tok_valid    = (cnt_reg != '0);
    assign token_start  = buf_reg[idx_reg].start;
    assign token_length = buf_reg[idx_reg].length;
    assign token_kind   = buf_reg[idx_reg].kind;
    assign unterminated = buf_reg[idx_reg].unterm;
    assign run_last     = (idx_ext + CNT_BITS'(1) == cnt_reg);

    assign out_take  = tok_valid && !tok_stall;
    assign last_take = out_take && run_last;
    assign buf_free  = (cnt_reg == '0) || last_take;
    assign advance   = src_vld_reg && buf_free;
    assign src_stall = src_vld_reg && !buf_free;
    assign src_take  = src_valid && !src_stall;

    // lexing of the registered byte
    always_comb
    begin
        res_t                slot [MAX_RESULTS];
        logic [MAX_RESULTS-1:0] slot_v;
        logic [IDX_BITS-1:0] wr;
        logic                done, ends_word, word_open, str_close;
        mode_t               m_new;
        logic [P-1:0]        os_new;
        logic                tp_new;
        logic [LW-1:0]       pos1;
        logic [LW-1:0]       flush_len;

        done      = tp_reg && (ch_reg == CH_AT);
        ends_word = is_blank(ch_reg) || (ch_reg == CH_QUOTE) ||
                    (ch_reg == CH_TILDE) || is_punct(ch_reg);
        word_open = (mode_reg == MODE_WORD) && (pos_reg > os_reg);
        str_close = (mode_reg == MODE_STRING) && (ch_reg == CH_QUOTE) && !pb_reg;

        m_new  = mode_reg;
        os_new = os_reg;
        tp_new = 1'b0;
        if (!done) begin
            if (mode_reg == MODE_STRING) begin
                if (str_close)
                    m_new = MODE_SPACE;
            end else if (ends_word) begin
                m_new = MODE_SPACE;
                if (ch_reg == CH_QUOTE) begin
                    os_new = pos_reg;
                    m_new  = MODE_STRING;
                end else if (ch_reg == CH_TILDE) begin
                    os_new = pos_reg;
                    tp_new = 1'b1;
                end
            end else if (mode_reg != MODE_WORD) begin
                os_new = pos_reg;
                m_new  = MODE_WORD;
            end
        end

        // pending tilde resolves first
        slot_v[0]      = tp_reg;
        slot[0].start  = clamp_out(CW'(os_reg));
        slot[0].length = done ? OUT_BITS'(2) : OUT_BITS'(1);
        slot[0].kind   = done ? KIND_SPLICE : KIND_PUNCT;
        slot[0].unterm = 1'b0;

        // closed string or word ended by this byte
        slot_v[1]      = !done && (str_close ||
                         ((mode_reg != MODE_STRING) && ends_word && word_open));
        slot[1].start  = clamp_out(CW'(os_reg));
        slot[1].length = str_close ?
                         clamp_out(CW'(LW'(pos_reg) - LW'(os_reg) + LW'(1))) :
                         clamp_out(CW'(pos_reg - os_reg));
        slot[1].kind   = str_close ? KIND_STRING : KIND_WORD;
        slot[1].unterm = 1'b0;

        // single-byte punctuation
        slot_v[2]      = !done && (mode_reg != MODE_STRING) && is_punct(ch_reg);
        slot[2].start  = clamp_out(CW'(pos_reg));
        slot[2].length = OUT_BITS'(1);
        slot[2].kind   = KIND_PUNCT;
        slot[2].unterm = 1'b0;

        // end of text flush
        pos1      = LW'(pos_reg) + LW'(1);
        flush_len = pos1 - LW'(os_new);
        slot[3].start  = clamp_out(CW'(os_new));
        slot[3].unterm = 1'b0;
        slot_v[3]      = 1'b0;
        if (tp_new) begin
            slot_v[3]      = eot_reg;
            slot[3].length = OUT_BITS'(1);
            slot[3].kind   = KIND_PUNCT;
        end else if (m_new == MODE_STRING) begin
            slot_v[3]      = eot_reg;
            slot[3].length = clamp_out(CW'(flush_len));
            slot[3].kind   = KIND_STRING;
            slot[3].unterm = 1'b1;
        end else begin
            slot_v[3]      = eot_reg && (m_new == MODE_WORD) && (pos1 > LW'(os_new));
            slot[3].length = clamp_out(CW'(flush_len));
            slot[3].kind   = KIND_WORD;
        end

        // pack valid slots in order
        buf_next = buf_reg;
        wr       = '0;
        new_cnt  = '0;
        for (int k = 0; k < MAX_RESULTS; k++) begin
            if (slot_v[k]) begin
                buf_next[wr] = slot[k];
                wr           = wr + IDX_BITS'(1);
                new_cnt      = new_cnt + CNT_BITS'(1);
            end
        end
        if (!advance)
            buf_next = buf_reg;

        mode_next = mode_reg;
        pos_next  = pos_reg;
        os_next   = os_reg;
        pb_next   = pb_reg;
        tp_next   = tp_reg;
        if (advance) begin
            if (eot_reg) begin
                mode_next = MODE_WORD;
                pos_next  = '0;
                os_next   = '0;
                pb_next   = 1'b0;
                tp_next   = 1'b0;
            end else begin
                mode_next = m_new;
                pos_next  = (pos_reg < POS_MAX) ? pos_reg + P'(1) : POS_MAX;
                os_next   = os_new;
                pb_next   = (ch_reg == CH_BSLASH);
                tp_next   = tp_new;
            end
        end
    end

    always_comb
    begin
        src_vld_next = src_vld_reg;
        if (src_take)
            src_vld_next = 1'b1;
        else if (advance)
            src_vld_next = 1'b0;

        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (advance) begin
            cnt_next = new_cnt;
            idx_next = '0;
        end else if (last_take) begin
            cnt_next = '0;
            idx_next = '0;
        end else if (out_take) begin
            idx_next = idx_reg + IDX_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            src_vld_reg <= 1'b0;
            mode_reg    <= MODE_WORD;
            pos_reg     <= '0;
            os_reg      <= '0;
            pb_reg      <= 1'b0;
            tp_reg      <= 1'b0;
            cnt_reg     <= '0;
            idx_reg     <= '0;
        end else begin
            src_vld_reg <= src_vld_next;
            mode_reg    <= mode_next;
            pos_reg     <= pos_next;
            os_reg      <= os_next;
            pb_reg      <= pb_next;
            tp_reg      <= tp_next;
            cnt_reg     <= cnt_next;
            idx_reg     <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_take) begin
            ch_reg  <= char_code;
            eot_reg <= end_of_text;
        end
        buf_reg <= buf_next;
    end

    `LTS_ASSERT_IMP(a_idx_in_range, clk, rst_n, cnt_reg != '0, idx_ext < cnt_reg)
    `LTS_ASSERT_IMP(a_tilde_mode, clk, rst_n, tp_reg, mode_reg == MODE_SPACE)
    `LTS_ASSERT_NXT(a_drain_empty, clk, rst_n, last_take && !src_vld_reg, !tok_valid)
    `LTS_ASSERT_NXT(a_eot_reset, clk, rst_n, advance && eot_reg,
                    pos_reg == '0 && mode_reg == MODE_WORD && !tp_reg && !pb_reg)

endmodule
